FILE: rtl/nine_patch_tiled_source_map_assert.svh
// ----------------------------------------------------------------------------
// nine-patch source map assertion macros
// shared concurrent check forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef NINE_PATCH_TILED_SOURCE_MAP_ASSERT_SVH
`define NINE_PATCH_TILED_SOURCE_MAP_ASSERT_SVH

// same-cycle implication
`define NPTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nine-patch map check failed");

// next-cycle implication
`define NPTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nine-patch map check failed");

`endif

FILE: rtl/npts_pkg.sv
// ----------------------------------------------------------------------------
// npts_pkg
// shared widths, limits and pipeline word types of the nine-patch source map
// ----------------------------------------------------------------------------
`default_nettype none

package npts_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned REGION_W   = 4;
  localparam int unsigned MAX_DIM    = 1024;
  localparam int unsigned STEP_BITS  = 2;
  localparam int unsigned REM_STAGES = COORD_W / STEP_BITS;
  localparam int unsigned REM_W      = CFG_W;

  localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

  typedef enum logic [1:0] {
    CLS_NEAR = 2'd0,
    CLS_MID  = 2'd1,
    CLS_FAR  = 2'd2
  } cls_t;

  typedef struct packed {
    logic               err;
    cls_t               cls;
    logic [COORD_W-1:0] base;
    logic               is_mid;
    logic [COORD_W-1:0] dividend;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   divisor;
  } axis_work_t;

  typedef struct packed {
    axis_work_t x;
    axis_work_t y;
  } work_t;

endpackage

`default_nettype wire

FILE: rtl/npts_axis_front.sv
// ----------------------------------------------------------------------------
// npts_axis_front
// per-axis checks, region class and far/near source, divide operands
// ----------------------------------------------------------------------------
`default_nettype none

module npts_axis_front (
  input  logic [npts_pkg::COORD_W-1:0] coord,
  input  logic [npts_pkg::CFG_W-1:0]   near,
  input  logic [npts_pkg::CFG_W-1:0]   far,
  input  logic [npts_pkg::CFG_W-1:0]   src_size,
  input  logic [npts_pkg::CFG_W-1:0]   dst_size,
  output npts_pkg::axis_work_t         work
);
  import npts_pkg::*;

  logic signed [CFG_W+1:0] mid;
  logic                    oversize;
  logic                    mid_bad;
  logic                    far_big;
  logic                    outside;
  logic                    is_far;
  logic                    is_near;
  logic [CFG_W:0]          far_src;

  assign mid      = $signed({2'b00, src_size}) - $signed({2'b00, near})
                  - $signed({2'b00, far});
  assign oversize = ({6'd0, src_size} > MAX_DIM_V) || ({6'd0, dst_size} > MAX_DIM_V);
  assign mid_bad  = mid[CFG_W+1] || (mid == '0);
  assign far_big  = far > dst_size;
  assign outside  = {1'b0, coord} >= dst_size;
  assign is_far   = ({2'b00, coord} + {1'b0, far}) >= {1'b0, dst_size};
  assign is_near  = {1'b0, coord} < near;
  assign far_src  = {1'b0, src_size} + {2'b00, coord} - {1'b0, dst_size};

  always_comb begin
    work          = '0;
    work.err      = oversize || mid_bad || far_big || outside;
    work.divisor  = mid[REM_W-1:0];
    work.dividend = coord - near[COORD_W-1:0];
    priority if (is_far) begin
      work.cls  = CLS_FAR;
      work.base = far_src[COORD_W-1:0];
    end else if (is_near) begin
      work.cls  = CLS_NEAR;
      work.base = coord;
    end else begin
      work.cls    = CLS_MID;
      work.base   = near[COORD_W-1:0];
      work.is_mid = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/npts_rem_step.sv
// ----------------------------------------------------------------------------
// npts_rem_step
// one registered restoring-remainder stage, two dividend bits per axis
// ----------------------------------------------------------------------------
`default_nettype none

module npts_rem_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  npts_pkg::work_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output npts_pkg::work_t out_data
);
  import npts_pkg::*;

  work_t step_data;

  function automatic axis_work_t step_axis(input axis_work_t a);
    axis_work_t    r;
    logic [REM_W:0] t;
    r = a;
    for (int i = 0; i < STEP_BITS; i++) begin
      t          = {r.rem, r.dividend[COORD_W-1]};
      r.dividend = {r.dividend[COORD_W-2:0], 1'b0};
      if (t >= {1'b0, r.divisor}) begin
        t = t - {1'b0, r.divisor};
      end
      r.rem = t[REM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    step_data.x = step_axis(in_data.x);
    step_data.y = step_axis(in_data.y);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= step_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nine_patch_tiled_source_map.sv
// ----------------------------------------------------------------------------
// nine_patch_tiled_source_map: destination pixel to nine-patch source pixel
// path: front register, five-stage remainder pipe of 2 bits each, output register
// throughput: one word per cycle while m_tready is high, set by the remainder pipe
// reset: synchronous; registers return to borders 0 and sizes 16, pipe empties
// ----------------------------------------------------------------------------
`default_nettype none
`include "nine_patch_tiled_source_map_assert.svh"

module nine_patch_tiled_source_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // dest_x[9:0], dest_y[19:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // src_x[9:0], src_y[19:10], region[23:20]
  output logic        m_tuser,   // map_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import npts_pkg::*;

  typedef enum logic [2:0] {
    REG_BORDER_LEFT   = 3'd0,
    REG_BORDER_TOP    = 3'd1,
    REG_BORDER_RIGHT  = 3'd2,
    REG_BORDER_BOTTOM = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5,
    REG_DEST_WIDTH    = 3'd6,
    REG_DEST_HEIGHT   = 3'd7
  } cfg_reg_t;

  logic [CFG_W-1:0] border_left;
  logic [CFG_W-1:0] border_top;
  logic [CFG_W-1:0] border_right;
  logic [CFG_W-1:0] border_bottom;
  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic [CFG_W-1:0] dest_width;
  logic [CFG_W-1:0] dest_height;

  cfg_reg_t         reg_sel;
  logic [CFG_W-1:0] reg_rdata;

  axis_work_t front_x;
  axis_work_t front_y;
  logic       a_valid;
  work_t      a_data;

  logic  pipe_valid [REM_STAGES+1];
  logic  pipe_ready [REM_STAGES+1];
  work_t pipe_data  [REM_STAGES+1];

  work_t              last;
  logic               out_err;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic [REGION_W-1:0] region;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      border_left   <= '0;
      border_top    <= '0;
      border_right  <= '0;
      border_bottom <= '0;
      source_width  <= CFG_W'(16);
      source_height <= CFG_W'(16);
      dest_width    <= CFG_W'(16);
      dest_height   <= CFG_W'(16);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_BORDER_LEFT:   border_left   <= pwdata[CFG_W-1:0];
        REG_BORDER_TOP:    border_top    <= pwdata[CFG_W-1:0];
        REG_BORDER_RIGHT:  border_right  <= pwdata[CFG_W-1:0];
        REG_BORDER_BOTTOM: border_bottom <= pwdata[CFG_W-1:0];
        REG_SOURCE_WIDTH:  source_width  <= pwdata[CFG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= pwdata[CFG_W-1:0];
        REG_DEST_WIDTH:    dest_width    <= pwdata[CFG_W-1:0];
        REG_DEST_HEIGHT:   dest_height   <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BORDER_LEFT:   reg_rdata = border_left;
      REG_BORDER_TOP:    reg_rdata = border_top;
      REG_BORDER_RIGHT:  reg_rdata = border_right;
      REG_BORDER_BOTTOM: reg_rdata = border_bottom;
      REG_SOURCE_WIDTH:  reg_rdata = source_width;
      REG_SOURCE_HEIGHT: reg_rdata = source_height;
      REG_DEST_WIDTH:    reg_rdata = dest_width;
      REG_DEST_HEIGHT:   reg_rdata = dest_height;
    endcase
  end

  assign prdata = {{(32-CFG_W){1'b0}}, reg_rdata};

  // front stage
  npts_axis_front u_front_x (
    .coord    (s_tdata[COORD_W-1:0]),
    .near     (border_left),
    .far      (border_right),
    .src_size (source_width),
    .dst_size (dest_width),
    .work     (front_x)
  );

  npts_axis_front u_front_y (
    .coord    (s_tdata[2*COORD_W-1:COORD_W]),
    .near     (border_top),
    .far      (border_bottom),
    .src_size (source_height),
    .dst_size (dest_height),
    .work     (front_y)
  );

  assign s_tready = !a_valid || pipe_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
    end else if (pipe_ready[0]) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_data.x <= front_x;
      a_data.y <= front_y;
    end
  end

  assign pipe_valid[0] = a_valid;
  assign pipe_data[0]  = a_data;

  // remainder pipe
  for (genvar k = 0; k < REM_STAGES; k++) begin : g_rem
    npts_rem_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[k]),
      .in_ready  (pipe_ready[k]),
      .in_data   (pipe_data[k]),
      .out_valid (pipe_valid[k+1]),
      .out_ready (pipe_ready[k+1]),
      .out_data  (pipe_data[k+1])
    );
  end

  // output register
  assign last    = pipe_data[REM_STAGES];
  assign out_err = last.x.err || last.y.err;

  always_comb begin
    src_x  = last.x.base + (last.x.is_mid ? last.x.rem[COORD_W-1:0] : '0);
    src_y  = last.y.base + (last.y.is_mid ? last.y.rem[COORD_W-1:0] : '0);
    region = REGION_W'(3) * REGION_W'(last.y.cls) + REGION_W'(last.x.cls);
  end

  assign pipe_ready[REM_STAGES] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_valid[REM_STAGES] && pipe_ready[REM_STAGES]) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid[REM_STAGES] && pipe_ready[REM_STAGES]) begin
      m_tuser <= out_err;
      m_tdata <= out_err ? '0 : {region, src_y, src_x};
    end
  end

  `NPTS_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == 24'd0)
  `NPTS_ASSERT_NOW(a_region_range, m_tvalid && !m_tuser, m_tdata[23:20] <= 4'd8)
  `NPTS_ASSERT_NOW(a_front_free, !a_valid, s_tready)
  `NPTS_ASSERT_NEXT(a_front_load, s_tvalid && s_tready, a_valid)

endmodule

`default_nettype wire

FILE: bench/nine_patch_tiled_source_map_test.sv
// ----------------------------------------------------------------------------
// nine_patch_tiled_source_map_test
// drives destination pixels through the stream port under several border and
// size setups written over apb, predicts each source pixel, region and error
// flag, and checks every output word in order under random idling
// ----------------------------------------------------------------------------
`default_nettype none

module nine_patch_tiled_source_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import npts_pkg::*;

  typedef enum logic [2:0] {
    REG_BORDER_LEFT   = 3'd0,
    REG_BORDER_TOP    = 3'd1,
    REG_BORDER_RIGHT  = 3'd2,
    REG_BORDER_BOTTOM = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5,
    REG_DEST_WIDTH    = 3'd6,
    REG_DEST_HEIGHT   = 3'd7
  } geom_reg_t;

  typedef enum int {
    AXIS_EMPTY_MID,
    AXIS_FAR_OVER,
    AXIS_OVERSIZE,
    AXIS_SMALL,
    AXIS_WIDE
  } axis_kind_t;

  typedef struct packed {
    logic               err;
    logic [REGION_W-1:0] region;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sx;
  } source_px_t;

  typedef int geom_set_t [8];

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // dest_x[9:0], dest_y[19:10], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // src_x[9:0], src_y[19:10], region[23:20]
  logic        m_tuser;   // map_error
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [CFG_W-1:0] geom [8];
  source_px_t       expected_px [$];
  int               fail_count;
  int               words_sent;
  int               words_seen;
  int               error_words;
  int               geom_count;
  int               cycle_count;
  int               send_gap_pct;
  int               recv_stall_pct;
  logic [8:0]       regions_seen;

  nine_patch_tiled_source_map u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit resolve_axis(int coord, int near, int far, int ssz, int dsz,
                                      output int src, output cls_t cls);
    int mid;
    int fin;
    src = 0;
    cls = CLS_NEAR;
    mid = ssz - near - far;
    if (ssz > MAX_DIM || dsz > MAX_DIM) return 1'b0;
    if (mid <= 0) return 1'b0;
    if (far > dsz) return 1'b0;
    if (coord >= dsz) return 1'b0;
    fin = dsz - far;
    if (coord >= fin) begin
      src = (ssz - far) + (coord - fin);
      cls = CLS_FAR;
    end else if (coord < near) begin
      src = coord;
      cls = CLS_NEAR;
    end else begin
      src = near + ((coord - near) % mid);
      cls = CLS_MID;
    end
    return 1'b1;
  endfunction

  function automatic source_px_t resolve_pixel(int x, int y);
    source_px_t px;
    int         sx;
    int         sy;
    cls_t       cx;
    cls_t       cy;
    bit         okx;
    bit         oky;
    okx = resolve_axis(x, int'(geom[REG_BORDER_LEFT]), int'(geom[REG_BORDER_RIGHT]),
                       int'(geom[REG_SOURCE_WIDTH]), int'(geom[REG_DEST_WIDTH]), sx, cx);
    oky = resolve_axis(y, int'(geom[REG_BORDER_TOP]), int'(geom[REG_BORDER_BOTTOM]),
                       int'(geom[REG_SOURCE_HEIGHT]), int'(geom[REG_DEST_HEIGHT]), sy, cy);
    px = '0;
    if (okx && oky) begin
      px.sx     = sx[COORD_W-1:0];
      px.sy     = sy[COORD_W-1:0];
      px.region = REGION_W'(3 * int'(cy) + int'(cx));
    end else begin
      px.err = 1'b1;
    end
    return px;
  endfunction

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // result checker
  always @(posedge clk) begin
    source_px_t want;
    source_px_t got;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      got = {m_tuser, m_tdata[23:20], m_tdata[19:10], m_tdata[9:0]};
      if (!got.err) regions_seen[got.region] <= 1'b1;
      else error_words++;
      if (expected_px.size() == 0) begin
        report_fail($sformatf("unexpected word src_x=%0d src_y=%0d region=%0d err=%0b",
                              got.sx, got.sy, got.region, got.err));
      end else begin
        want = expected_px.pop_front();
        if (got !== want)
          report_fail($sformatf("exp src_x=%0d src_y=%0d region=%0d err=%0b, got %0d %0d %0d %0b",
                                want.sx, want.sy, want.region, want.err,
                                got.sx, got.sy, got.region, got.err));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input geom_reg_t r, input int v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(int'(r) * 4);
    pwdata  = {21'($urandom()), 11'(v)};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    geom[r] = 11'(v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_reg(input geom_reg_t r, output logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = 5'(int'(r) * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    v = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_idle;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input geom_set_t vals);
    wait_idle();
    for (int i = 0; i < 8; i++) write_reg(geom_reg_t'(i), vals[i]);
    geom_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input int x, input int y);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0, 10'(y), 10'(x)};
    do @(posedge clk); while (!s_tready);
    expected_px.push_back(resolve_pixel(x, y));
    words_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic test_reset_defaults;
    send_word(0, 0);
    send_word(15, 15);
    send_word(16, 3);
    send_word(1023, 1023);
  endtask

  task automatic test_register_access;
    logic [31:0] rd;
    int          v;
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      v = $urandom_range(0, 2047);
      write_reg(geom_reg_t'(i), v);
      read_reg(geom_reg_t'(i), rd);
      if (rd[10:0] !== 11'(v))
        report_fail($sformatf("register %0d read %0d, wrote %0d", i, rd[10:0], v));
    end
  endtask

  task automatic test_all_regions;
    int xs [3] = '{1, 8, 19};
    int ys [3] = '{2, 10, 29};
    set_geometry('{3, 4, 2, 5, 10, 12, 20, 30});
    foreach (ys[j]) foreach (xs[i]) send_word(xs[i], ys[j]);
  endtask

  task automatic test_border_overlap;
    // far border starts inside the near border
    set_geometry('{8, 8, 3, 3, 12, 12, 6, 6});
    send_word(2, 4);
    send_word(4, 2);
  endtask

  task automatic test_invalid_setups;
    set_geometry('{3, 0, 3, 0, 6, 16, 16, 16});
    send_word(5, 5);
    set_geometry('{0, 0, 5, 0, 16, 16, 4, 16});
    send_word(1, 1);
    set_geometry('{0, 0, 0, 0, 16, 1025, 16, 16});
    send_word(2, 2);
    set_geometry('{0, 0, 0, 0, 16, 16, 2047, 16});
    send_word(3, 3);
    set_geometry('{0, 0, 0, 0, 0, 16, 16, 16});
    send_word(0, 0);
  endtask

  task automatic test_extremes;
    set_geometry('{0, 0, 0, 0, 1024, 1024, 1024, 1024});
    send_word(1023, 1023);
    set_geometry('{1023, 0, 0, 1023, 1024, 1024, 1024, 1024});
    send_word(1023, 1023);
    set_geometry('{0, 0, 0, 0, 1, 1, 1, 1});
    send_word(0, 0);
    send_word(1, 0);
  endtask

  task automatic pick_axis(output int near, output int far, output int ssz, output int dsz);
    axis_kind_t kind;
    int         pick;
    pick = $urandom_range(0, 19);
    kind = (pick == 0) ? AXIS_EMPTY_MID :
           (pick == 1) ? AXIS_FAR_OVER :
           (pick == 2) ? AXIS_OVERSIZE :
           (pick <= 11) ? AXIS_SMALL : AXIS_WIDE;
    case (kind)
      AXIS_EMPTY_MID: begin
        ssz  = $urandom_range(1, 1024);
        near = $urandom_range(0, ssz);
        far  = ssz - near + $urandom_range(0, 8);
        if (far > 1024) far = 1024;
        dsz  = $urandom_range((far > 0) ? far : 1, 1024);
      end
      AXIS_FAR_OVER: begin
        ssz  = $urandom_range(3, 1024);
        far  = $urandom_range(2, ssz - 1);
        near = $urandom_range(0, ssz - 1 - far);
        dsz  = $urandom_range(1, far - 1);
      end
      AXIS_OVERSIZE: begin
        near = $urandom_range(0, 4);
        far  = $urandom_range(0, 4);
        ssz  = $urandom_range(0, 1) ? $urandom_range(1025, 2047) : $urandom_range(10, 1024);
        dsz  = (ssz > 1024) ? $urandom_range(10, 2047) : $urandom_range(1025, 2047);
      end
      default: begin
        ssz  = (kind == AXIS_SMALL) ? $urandom_range(1, 40) : $urandom_range(1, 1024);
        near = $urandom_range(0, ssz - 1);
        far  = $urandom_range(0, ssz - 1 - near);
        dsz  = (kind == AXIS_SMALL) ? $urandom_range(1, 200) : $urandom_range(1, 1024);
        if (far > dsz) dsz = far;
      end
    endcase
  endtask

  task automatic test_random_traffic;
    int gaps   [3] = '{38, 72, 0};
    int stalls [3] = '{72, 38, 0};
    int nx, fx, sx, dx;
    int ny, fy, sy, dy;
    int x, y;
    for (int m = 0; m < 3; m++) begin
      for (int g = 0; g < 6; g++) begin
        pick_axis(nx, fx, sx, dx);
        pick_axis(ny, fy, sy, dy);
        set_geometry('{nx, ny, fx, fy, sx, sy, dx, dy});
        send_gap_pct   = gaps[m];
        recv_stall_pct = stalls[m];
        for (int n = 0; n < 60; n++) begin
          // mostly inside the destination, some anywhere in the field
          if ($urandom_range(99) < 85) begin
            x = $urandom_range(0, ((dx > 1024) ? 1024 : dx) - 1);
            y = $urandom_range(0, ((dy > 1024) ? 1024 : dy) - 1);
          end else begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
          end
          send_word(x, y);
        end
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_count     = 0;
    words_sent     = 0;
    words_seen     = 0;
    error_words    = 0;
    geom_count     = 0;
    cycle_count    = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    regions_seen   = '0;
    geom = '{11'd0, 11'd0, 11'd0, 11'd0, 11'd16, 11'd16, 11'd16, 11'd16};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_register_access();
    test_all_regions();
    test_border_overlap();
    test_invalid_setups();
    test_extremes();
    test_random_traffic();

    wait_idle();
    if (expected_px.size() != 0)
      report_fail($sformatf("%0d words never arrived", expected_px.size()));
    $display("sent %0d pixels under %0d geometries, %0d words back, %0d flagged as errors",
             words_sent, geom_count, words_seen, error_words);
    $display("regions seen %b, %0d mismatches", regions_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/npts_pkg.sv
rtl/npts_axis_front.sv
rtl/npts_rem_step.sv
rtl/nine_patch_tiled_source_map.sv
bench/nine_patch_tiled_source_map_test.sv
